// ===== hdl/m3mc_pkg.sv =====
package m3mc_pkg;

  // item kinds
  localparam logic [1:0] KIND_REG_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SRAM_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK       = 2'd2;

  // register decode on addr bits 15..13 and 0
  localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] REG_MIRRORING   = 16'hA000;
  localparam logic [15:0] REG_UNLOCK      = 16'hA001;
  localparam logic [15:0] REG_IRQ_COUNT   = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

  // bank_select low bits: target of a bank data write
  localparam logic [2:0] BS_CHR_2K_0 = 3'd0;
  localparam logic [2:0] BS_CHR_2K_1 = 3'd1;
  localparam logic [2:0] BS_CHR_1K_0 = 3'd2;
  localparam logic [2:0] BS_CHR_1K_1 = 3'd3;
  localparam logic [2:0] BS_CHR_1K_2 = 3'd4;
  localparam logic [2:0] BS_CHR_1K_3 = 3'd5;
  localparam logic [2:0] BS_PRG_0    = 3'd6;
  localparam logic [2:0] BS_PRG_1    = 3'd7;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_SCREEN    = 2'd1;

  localparam logic [8:0] PRG_BANK_COUNT_RESET = 9'd64;
  localparam int unsigned LAST_VISIBLE_LINE_DEFAULT = 239;

  localparam int unsigned CHR_REGS = 6;
  typedef logic [6:0] chr_reg_t;
  localparam chr_reg_t CHR_RESET [CHR_REGS] = '{7'd0, 7'd2, 7'd4, 7'd5, 7'd6, 7'd7};

  typedef logic [8:0] chr_bank_t;
  typedef logic [5:0] prg_bank_t;

endpackage

// ===== hdl/m3mc_if.sv =====
interface m3mc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] addr;
  logic [7:0]  data;
  logic [8:0]  scanline;
  logic        rendering_on;

  modport source(output valid, kind, addr, data, scanline, rendering_on, input ready);
  modport sink(input valid, kind, addr, data, scanline, rendering_on, output ready);
endinterface

interface m3mc_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] prg_map;
  logic [35:0] chr_map_low;
  logic [35:0] chr_map_high;
  logic        mirror_horizontal;
  logic        irq_pulse;

  modport source(output valid, prg_map, chr_map_low, chr_map_high, mirror_horizontal,
                 irq_pulse, input ready);
  modport sink(input valid, prg_map, chr_map_low, chr_map_high, mirror_horizontal,
               irq_pulse, output ready);
endinterface

interface m3mc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/mmc3_multicart_bank_mapper_unit.sv =====
// channel  dir  fields
// req      in   kind, addr, data, scanline, rendering_on
// rsp      out  prg_map, chr_map_low, chr_map_high, mirror_horizontal, irq_pulse
// cfg      in   index, data (prg_bank_count, four_screen)
//
// one word per cycle sustained while rsp is not stalled; an accepted word goes
// through the input register, then the result register, before rsp valid
// (state update and result register load in one pass)
// rst is synchronous: mapper registers return to power-on values, pipeline empties
// a stalled rsp holds the input register; req.ready drops only while both are full
// cfg is always ready and takes effect on the next word
module mmc3_multicart_bank_mapper_unit #(
  parameter int unsigned LAST_VISIBLE_LINE = m3mc_pkg::LAST_VISIBLE_LINE_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  m3mc_req_if.sink  req,
  m3mc_rsp_if.source rsp,
  m3mc_cfg_if.sink  cfg
);
  import m3mc_pkg::*;

  localparam logic [8:0] LAST_LINE = 9'(LAST_VISIBLE_LINE);

  // input register
  logic        pipe_valid;
  logic [1:0]  pipe_kind;
  logic [15:0] pipe_addr;
  logic [7:0]  pipe_data;
  logic [8:0]  pipe_scanline;
  logic        pipe_rend;

  // result register
  logic        rsp_valid;
  logic [23:0] rsp_prg_map;
  logic [35:0] rsp_chr_low;
  logic [35:0] rsp_chr_high;
  logic        rsp_mirror;
  logic        rsp_irq;

  // configuration
  logic [8:0] prg_bank_count;
  logic       four_screen;

  // mapper state
  logic [7:0] bank_select, bank_select_next;
  logic [7:0] outer_bank, outer_bank_next;
  logic       outer_unlock, outer_unlock_next;
  chr_reg_t   chr_bank [CHR_REGS];
  chr_reg_t   chr_bank_next [CHR_REGS];
  logic [3:0] prg_bank0, prg_bank0_next;
  logic [3:0] prg_bank1, prg_bank1_next;
  logic       mirroring, mirroring_next;
  logic       irq_enable, irq_enable_next;
  logic [7:0] irq_count, irq_count_next;
  logic [7:0] irq_reload, irq_reload_next;
  logic       pulse;

  logic advance;
  logic req_accept;

  assign advance    = !rsp_valid || rsp.ready;
  assign req.ready  = !pipe_valid || advance;
  assign req_accept = req.valid && req.ready;
  assign cfg.ready  = 1'b1;

  assign rsp.valid             = rsp_valid;
  assign rsp.prg_map           = rsp_prg_map;
  assign rsp.chr_map_low       = rsp_chr_low;
  assign rsp.chr_map_high      = rsp_chr_high;
  assign rsp.mirror_horizontal = rsp_mirror;
  assign rsp.irq_pulse         = rsp_irq;

  // state update for the word in the input register
  always_comb begin
    bank_select_next  = bank_select;
    outer_bank_next   = outer_bank;
    outer_unlock_next = outer_unlock;
    chr_bank_next     = chr_bank;
    prg_bank0_next    = prg_bank0;
    prg_bank1_next    = prg_bank1;
    mirroring_next    = mirroring;
    irq_enable_next   = irq_enable;
    irq_count_next    = irq_count;
    irq_reload_next   = irq_reload;
    pulse             = 1'b0;
    case (pipe_kind)
      KIND_REG_WRITE: begin
        unique case (pipe_addr & REG_DECODE_MASK)
          REG_BANK_SELECT: bank_select_next = pipe_data;
          REG_BANK_DATA: begin
            unique case (bank_select[2:0])
              BS_CHR_2K_0: chr_bank_next[0] = {pipe_data[6:1], 1'b0};
              BS_CHR_2K_1: chr_bank_next[1] = {pipe_data[6:1], 1'b0};
              BS_CHR_1K_0: chr_bank_next[2] = pipe_data[6:0];
              BS_CHR_1K_1: chr_bank_next[3] = pipe_data[6:0];
              BS_CHR_1K_2: chr_bank_next[4] = pipe_data[6:0];
              BS_CHR_1K_3: chr_bank_next[5] = pipe_data[6:0];
              BS_PRG_0:    prg_bank0_next   = pipe_data[3:0];
              BS_PRG_1:    prg_bank1_next   = pipe_data[3:0];
              default:     prg_bank1_next   = pipe_data[3:0];
            endcase
          end
          REG_MIRRORING: begin
            if (!four_screen) begin
              mirroring_next = pipe_data[0];
            end
          end
          REG_UNLOCK:      outer_unlock_next = pipe_data[7];
          REG_IRQ_COUNT:   irq_count_next    = pipe_data;
          REG_IRQ_RELOAD:  irq_reload_next   = pipe_data;
          REG_IRQ_DISABLE: irq_enable_next   = 1'b0;
          REG_IRQ_ENABLE:  irq_enable_next   = 1'b1;
          default: ;
        endcase
      end
      KIND_SRAM_WRITE: begin
        if (outer_unlock) begin
          outer_bank_next = pipe_data;
        end
      end
      KIND_TICK: begin
        if (irq_enable && pipe_scanline <= LAST_LINE && pipe_rend) begin
          if (irq_count == 8'd0) begin
            irq_count_next = irq_reload;
            pulse          = 1'b1;
          end else begin
            irq_count_next = irq_count - 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // maps from the updated state
  chr_bank_t chr_eff [CHR_REGS];
  logic [35:0] half_a, half_b;
  logic [3:0]  last_low;
  prg_bank_t   prg_slot [4];
  prg_bank_t   p0, p1, bank_fe, bank_ff;
  logic [23:0] prg_map_next;

  always_comb begin
    for (int i = 0; i < CHR_REGS; i++) begin
      chr_eff[i] = {outer_bank_next[7:6], chr_bank_next[i]};
    end
    half_a = {chr_eff[1][8:1], 1'b1, chr_eff[1], chr_eff[0][8:1], 1'b1, chr_eff[0]};
    half_b = {chr_eff[5], chr_eff[4], chr_eff[3], chr_eff[2]};

    // count-1 wraps, only the low nibble reaches the map
    last_low = prg_bank_count[3:0] - 4'd1;
    p0       = {outer_bank_next[7:6], prg_bank0_next};
    p1       = {outer_bank_next[7:6], prg_bank1_next};
    bank_fe  = {outer_bank_next[7:6], last_low[3:1], 1'b0};
    bank_ff  = {outer_bank_next[7:6], last_low};
    if (outer_bank_next[0]) begin
      if (bank_select_next[6]) begin
        prg_slot = '{bank_fe, p1, p0, bank_ff};
      end else begin
        prg_slot = '{p0, p1, bank_fe, bank_ff};
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        prg_slot[i] = {1'b0, outer_bank_next[6:4], 2'(i)};
      end
    end
    prg_map_next = {prg_slot[3], prg_slot[2], prg_slot[1], prg_slot[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid     <= 1'b0;
      rsp_valid      <= 1'b0;
      prg_bank_count <= PRG_BANK_COUNT_RESET;
      four_screen    <= 1'b0;
      bank_select    <= '0;
      outer_bank     <= '0;
      outer_unlock   <= 1'b0;
      chr_bank       <= CHR_RESET;
      prg_bank0      <= 4'd0;
      prg_bank1      <= 4'd1;
      mirroring      <= 1'b0;
      irq_enable     <= 1'b0;
      irq_count      <= '0;
      irq_reload     <= '0;
    end else begin
      if (req_accept) begin
        pipe_valid <= 1'b1;
      end else if (advance) begin
        pipe_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= pipe_valid;
      end
      if (cfg.valid) begin
        case (cfg.index)
          CFG_PRG_BANK_COUNT: prg_bank_count <= cfg.data;
          CFG_FOUR_SCREEN:    four_screen    <= cfg.data[0];
          default: ;
        endcase
      end
      if (pipe_valid && advance) begin
        bank_select  <= bank_select_next;
        outer_bank   <= outer_bank_next;
        outer_unlock <= outer_unlock_next;
        chr_bank     <= chr_bank_next;
        prg_bank0    <= prg_bank0_next;
        prg_bank1    <= prg_bank1_next;
        mirroring    <= mirroring_next;
        irq_enable   <= irq_enable_next;
        irq_count    <= irq_count_next;
        irq_reload   <= irq_reload_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_accept) begin
      pipe_kind     <= req.kind;
      pipe_addr     <= req.addr;
      pipe_data     <= req.data;
      pipe_scanline <= req.scanline;
      pipe_rend     <= req.rendering_on;
    end
    if (pipe_valid && advance) begin
      rsp_prg_map <= prg_map_next;
      rsp_chr_low <= bank_select_next[7] ? half_b : half_a;
      rsp_chr_high <= bank_select_next[7] ? half_a : half_b;
      rsp_mirror  <= four_screen ? 1'b0 : mirroring_next;
      rsp_irq     <= pulse;
    end
  end

`ifndef SYNTHESIS
  a_pulse_needs_enable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_irq |-> irq_enable)
    else $error("irq pulse while interrupt disabled");

  a_four_screen_mirror: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && four_screen |-> !rsp_mirror)
    else $error("mirroring reported on four-screen cartridge");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    pipe_valid && !advance |=> pipe_valid && $stable(pipe_data) && $stable(pipe_addr))
    else $error("input register lost a word under stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !pipe_valid && !rsp_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
